// ===== hw/rtl/md5_pkg.sv =====
// Package for the MD5 hash engine: state encoding, initial chaining values,
// round constant and shift tables, and the message word schedule.
// No dependencies.
package md5_pkg;

  // Sequencer states of the engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } md5_state_e;

  // Initial chaining values.
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Padding marker byte and the byte position where the length field starts.
  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] LENGTH_POS = 6'd56;

  // Message block geometry.
  localparam int unsigned BLOCK_WORDS = 16;
  localparam logic [5:0]  LAST_BYTE_POS = 6'd63;
  localparam logic [5:0]  LAST_ROUND = 6'd63;

  // Sine-derived additive constants, one per round.
  localparam logic [31:0] SINE_ROM [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts, indexed by {round group, round mod 4}.
  localparam logic [4:0] SHIFT_ROM [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] round);
    logic [3:0] r;
    logic [7:0] p;
    r = round[3:0];
    p = 8'd0;
    unique case (round[5:4])
      2'd0: p = {4'd0, r};
      2'd1: p = 8'(r * 4'd5) + 8'd1;
      2'd2: p = 8'(r * 4'd3) + 8'd5;
      default: p = 8'(r * 4'd7);
    endcase
    return p[3:0];
  endfunction

  // Rotate a word left by a nonzero amount below 32.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} << s;
    return w[63:32];
  endfunction

endpackage

// ===== hw/rtl/md5_if.sv =====
// Valid/ready channel interfaces of the MD5 hash engine.
// One interface for message bytes and one for digest words; no dependencies.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  logic       is_empty;

  modport source (output valid, output data_byte, output is_last, output is_empty,
                  input ready);
  modport sink (input valid, input data_byte, input is_last, input is_empty,
                output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ===== hw/rtl/md5_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/md5_hash_engine_core.sv =====
// MD5 digest engine: byte intake, padding, one-round-per-cycle compression.
// Depends on md5_pkg, the interfaces in md5_if.sv and md5_ram.
//
// Usage: message bytes arrive on in_i, one per transfer, in order. A transfer
// with is_last set closes the message; is_empty set means the transfer carries
// no byte (an empty transfer without is_last is simply dropped).
// After the close, four digest words leave on out_o, word_index 0 to 3, with
// last_word set on the fourth. The digest bytes are each word little-endian.
// Timing: the 64th byte of a block starts a compression (a read prefetch, 64
// rounds through the shared round adder, a chaining update), and no byte is
// taken until it ends. Closing feeds the padding and length bytes one per
// cycle through the same byte path, then one or two compressions, then the
// four digest words. The block is busy (ready low) throughout.
// Reset: chaining words return to the initial values, the byte count and bit
// length clear; the block buffer RAM is not cleared and needs no sweep.
// Stall: while the receiver holds ready low a digest word stays on out_o
// unchanged; after the fourth transfer the engine reinitializes and takes a new
// message on the next cycle.
module md5_hash_engine_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);
  import md5_pkg::*;

  localparam int unsigned AddrW = $clog2(BLOCK_WORDS);

  md5_state_e  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  round_q, round_d;
  logic [1:0]  idx_q, idx_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a_d, b_d, c_d, d_d;
  logic [23:0] acc_q, acc_d;
  logic        pad_q, pad_d;
  logic        marker_q, marker_d;
  logic        len_ok_q, len_ok_d;
  logic        final_q, final_d;

  // Byte path into the block buffer.
  logic             wr_en;
  logic [7:0]       wr_byte;
  logic [31:0]      ram_wdata;
  logic             ram_we;
  logic [AddrW-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  // Round datapath.
  logic [31:0] f_val;
  logic [31:0] round_sum;
  logic [31:0] b_new;
  logic [7:0]  pad_byte;

  assign ram_wdata = {wr_byte, acc_q};
  assign ram_we    = wr_en && (fill_q[1:0] == 2'd3);

  md5_ram #(
    .Width(32),
    .Depth(BLOCK_WORDS)
  ) u_block_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[5:2]),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Padding byte: marker first, then zeros, and the length in the final block.
  always_comb begin
    pad_byte = 8'h00;
    if (!marker_q) begin
      pad_byte = PAD_MARKER;
    end else if (len_ok_q && (fill_q >= LENGTH_POS)) begin
      pad_byte = bitlen_q[{fill_q[2:0], 3'b000} +: 8];
    end
  end

  // One MD5 round on the working registers.
  always_comb begin
    unique case (round_q[5:4])
      2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1: f_val = (d_q & b_q) | (~d_q & c_q);
      2'd2: f_val = b_q ^ c_q ^ d_q;
      default: f_val = c_q ^ (b_q | ~d_q);
    endcase
    round_sum = a_q + f_val + SINE_ROM[round_q] + ram_rdata;
    b_new     = b_q + rotl32(round_sum, SHIFT_ROM[{round_q[5:4], round_q[1:0]}]);
  end

  // Sequencer: next state, register updates and channel outputs.
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    round_d   = round_q;
    idx_d     = idx_q;
    bitlen_d  = bitlen_q;
    chain_d   = chain_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    d_d       = d_q;
    acc_d     = acc_q;
    pad_d     = pad_q;
    marker_d  = marker_q;
    len_ok_d  = len_ok_q;
    final_d   = final_q;
    wr_en     = 1'b0;
    wr_byte   = in_i.data_byte;
    ram_raddr = '0;
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // Ready is high here, so a valid input is a transfer.
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (!in_i.is_empty) begin
            wr_en    = 1'b1;
            bitlen_d = bitlen_q + 64'd8;
          end
          final_d = 1'b0;
          if (!in_i.is_empty && (fill_q == LAST_BYTE_POS)) begin
            pad_d   = in_i.is_last;
            state_d = ST_LOAD;
          end else if (in_i.is_last) begin
            pad_d    = 1'b1;
            marker_d = 1'b0;
            state_d  = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        wr_en    = 1'b1;
        wr_byte  = pad_byte;
        marker_d = 1'b1;
        if (!marker_q) begin
          len_ok_d = (fill_q < LENGTH_POS);
        end
        if (fill_q == LAST_BYTE_POS) begin
          final_d = marker_q && len_ok_q;
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        // Prefetch the first message word and load the working registers.
        ram_raddr = msg_index(6'd0);
        a_d       = chain_q[0];
        b_d       = chain_q[1];
        c_d       = chain_q[2];
        d_d       = chain_q[3];
        round_d   = '0;
        state_d   = ST_ROUND;
      end

      ST_ROUND: begin
        ram_raddr = msg_index(round_q + 6'd1);
        a_d       = d_q;
        b_d       = b_new;
        c_d       = b_q;
        d_d       = c_q;
        round_d   = round_q + 6'd1;
        if (round_q == LAST_ROUND) begin
          state_d = ST_FINAL;
        end
      end

      ST_FINAL: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        if (final_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else if (pad_q) begin
          len_ok_d = 1'b1;
          state_d  = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_OUT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            chain_d[0] = IV_A;
            chain_d[1] = IV_B;
            chain_d[2] = IV_C;
            chain_d[3] = IV_D;
            bitlen_d   = '0;
            fill_d     = '0;
            pad_d      = 1'b0;
            marker_d   = 1'b0;
            len_ok_d   = 1'b0;
            final_d    = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // A written byte shifts into the word assembler and advances the count.
    if (wr_en) begin
      acc_d  = {wr_byte, acc_q[23:8]};
      fill_d = fill_q + 6'd1;
    end
  end

  assign out_o.digest_word = chain_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 2'd3);

  // Control state and chaining registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      round_q    <= '0;
      idx_q      <= '0;
      bitlen_q   <= '0;
      chain_q[0] <= IV_A;
      chain_q[1] <= IV_B;
      chain_q[2] <= IV_C;
      chain_q[3] <= IV_D;
      pad_q      <= 1'b0;
      marker_q   <= 1'b0;
      len_ok_q   <= 1'b0;
      final_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      round_q  <= round_d;
      idx_q    <= idx_d;
      bitlen_q <= bitlen_d;
      chain_q  <= chain_d;
      pad_q    <= pad_d;
      marker_q <= marker_d;
      len_ok_q <= len_ok_d;
      final_q  <= final_d;
    end
  end

  // Working registers and byte assembler carry payload only.
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    acc_q <= acc_d;
  end

endmodule

// ===== hw/rtl/md5_hash_engine_chk.sv =====
// Port-level checks for md5_hash_engine_core, attached with a bind statement.
// Depends only on the top level's ports.
module md5_hash_engine_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] digest_word_i,
  input logic [1:0]  word_index_i,
  input logic        last_word_i
);

  // The engine never takes bytes while it presents a digest word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && in_ready_i))
  else $error("input ready while a digest word is pending");

  // A stalled digest word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(digest_word_i) && $stable(word_index_i))
  else $error("stalled digest word changed");

  // Words leave in order without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_word_i |=>
      out_valid_i && (word_index_i == $past(word_index_i) + 2'd1))
  else $error("digest word sequence broken");

  // The last flag marks the fourth word only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_word_i == (word_index_i == 2'd3)))
  else $error("last_word does not match word_index");

  // After the final word transfer the engine is ready for a new message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_word_i |=> in_ready_i && !out_valid_i)
  else $error("engine not ready after digest");

endmodule

bind md5_hash_engine_core md5_hash_engine_chk u_md5_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .digest_word_i(out_o.digest_word),
  .word_index_i (out_o.word_index),
  .last_word_i  (out_o.last_word)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for md5_hash_engine_core: random and directed messages
// are hashed by a built-in MD5 digest predictor and every digest word is compared.
// Depends on md5_pkg and the channel interfaces in md5_if.sv.
typedef struct packed {
  logic [31:0] word;
  logic [1:0]  index;
  logic        last;
} digest_word_t;

// Keeps its own copy of the hash state and the digest words still to arrive.
class digest_scoreboard;
  bit [31:0]    chain[4];
  bit [7:0]     block[64];
  int unsigned  fill;
  bit [63:0]    bit_len;
  bit [31:0]    sine_tab[64];
  bit [4:0]     shift_tab[16];
  digest_word_t digest_due[$];
  int           errors;

  function new();
    real        s;
    bit [63:0]  scaled;
    // Round constants are floor(|sin(i + 1)| * 2^32), worked out here.
    for (int i = 0; i < 64; i++) begin
      s = $sin(i + 1);
      if (s < 0.0) begin
        s = -s;
      end
      scaled = $floor(s * 4294967296.0);
      sine_tab[i] = scaled[31:0];
    end
    shift_tab = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
                  5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    fill = 0;
    bit_len = '0;
  endfunction

  // One 64-round compression of the current block into the chaining words.
  function void compress();
    bit [31:0] m[16];
    bit [31:0] a, b, c, d, f, t, sum;
    int unsigned g;
    bit [4:0]  sh;
    for (int j = 0; j < 16; j++) begin
      m[j] = {block[4*j+3], block[4*j+2], block[4*j+1], block[4*j]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d);
        g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c);
        g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d;
        g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d);
        g = (7 * i) % 16;
      end
      sh  = shift_tab[(i / 16) * 4 + (i % 4)];
      sum = a + f + sine_tab[i] + m[g];
      t = d;
      d = c;
      c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    fill = 0;
  endfunction

  function void put_byte(bit [7:0] v);
    block[fill] = v;
    fill++;
  endfunction

  // Update the predicted state with one accepted input transfer.
  function void absorb_item(bit [7:0] data, bit last, bit empty);
    digest_word_t w;
    if (!empty) begin
      put_byte(data);
      bit_len += 64'd8;
      if (fill == 64) begin
        compress();
      end
    end
    if (!last) begin
      return;
    end
    // Marker, zero fill (one more block when the marker lands in the length
    // field), then the little-endian bit length.
    put_byte(8'h80);
    if (fill > 56) begin
      while (fill < 64) begin
        put_byte(8'h00);
      end
      compress();
    end
    while (fill < 56) begin
      put_byte(8'h00);
    end
    for (int i = 0; i < 8; i++) begin
      put_byte(bit_len[8*i +: 8]);
    end
    compress();
    for (int i = 0; i < 4; i++) begin
      w.word  = chain[i];
      w.index = i[1:0];
      w.last  = (i == 3);
      digest_due.push_back(w);
    end
    restart();
  endfunction

  // Compare one accepted digest word with the oldest one due.
  function void check_word(logic [31:0] word, logic [1:0] index, logic last);
    digest_word_t exp_w;
    if (digest_due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: digest word %h idx %0d last %0d with none expected",
                 word, index, last);
      end
      return;
    end
    exp_w = digest_due.pop_front();
    if (word !== exp_w.word || index !== exp_w.index || last !== exp_w.last) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: expected word %h idx %0d last %0d, got %h idx %0d last %0d",
                 exp_w.word, exp_w.index, exp_w.last, word, index, last);
      end
    end
  endfunction

  function int unsigned words_due();
    return digest_due.size();
  endfunction
endclass

module tb_top;
  logic clk;
  logic rst_n;

  md5_in_if  in_if ();
  md5_out_if out_if ();

  md5_hash_engine_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  digest_scoreboard sb = new();

  bit          in_rush;
  bit          out_rush;
  int unsigned random_items;
  int unsigned messages;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // Overall time limit.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Send one item after a random gap and wait for its transfer.
  task automatic send_item(input logic [7:0] data, input logic last, input logic empty);
    int unsigned gap;
    gap = in_rush ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= data;
    in_if.is_last   <= last;
    in_if.is_empty  <= empty;
    do begin
      @(posedge clk);
    end while (!(in_if.valid && in_if.ready));
    sb.absorb_item(in_if.data_byte, in_if.is_last, in_if.is_empty);
  endtask

  // Hold the sender off until every digest word due has been taken.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.words_due() != 0) begin
      @(posedge clk);
    end
  endtask

  // One message of random bytes, with stray empty transfers mixed in; it is
  // closed either on its last byte or by an empty closing transfer.
  task automatic send_message(input int unsigned len, input bit close_empty);
    in_rush = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b1);
      end
      send_item(8'($urandom), (k == len - 1) && !close_empty, 1'b0);
      random_items++;
    end
    if (close_empty || len == 0) begin
      send_item(8'($urandom), 1'b1, 1'b1);
      random_items++;
    end
    messages++;
  endtask

  // Receiver: random stalls before each digest word, with stall-free stretches.
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    out_rush = 1'b0;
    @(posedge rst_n);
    stall = $urandom_range(0, 11);
    forever begin
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!(out_if.valid && out_if.ready));
      sb.check_word(out_if.digest_word, out_if.word_index, out_if.last_word);
      if ($urandom_range(0, 7) == 0) begin
        out_rush = ~out_rush;
      end
      stall = out_rush ? 0 : $urandom_range(0, 11);
    end
  end

  // Reset, directed cases, random messages and the final check.
  initial begin
    int unsigned kind;
    int unsigned len;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.is_last   <= 1'b0;
    in_if.is_empty  <= 1'b0;
    rst_n           <= 1'b0;
    in_rush      = 1'b0;
    random_items = 0;
    messages     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Message of zero bytes, closed by an empty transfer.
    send_item(8'hA5, 1'b1, 1'b1);
    // Single-byte messages at both byte extremes.
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    // The classic "abc" message.
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    // Empty transfers without close are dropped; then an empty close.
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hC3, 1'b0, 1'b1);
    send_item(8'h3C, 1'b1, 1'b1);
    wait_drained();

    // Marker lands at byte 56, so padding needs a second block.
    send_message(56, 1'b0);
    // The closing byte fills a block; padding goes into a fresh one.
    send_message(64, 1'b0);
    while (random_items < 140 || messages < 4) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        len = $urandom_range(0, 10);
      end else if (kind == 5) begin
        len = $urandom_range(55, 57);
      end else if (kind == 6) begin
        len = $urandom_range(63, 65);
      end else begin
        len = $urandom_range(1, 30);
      end
      send_message(len, (len == 0) || ($urandom_range(0, 3) == 0));
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
      end
    end

    in_if.valid <= 1'b0;
    while (sb.words_due() != 0) begin
      @(posedge clk);
    end
    repeat (250) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
